### sv/rdm_pkg.sv
package rdm_pkg;

    // coordinate word, signed fixed point (Q16.16 at the default width)
    localparam int COORD_BITS = 32;

    // derived widths
    localparam int DIST_BITS  = COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int T2_BITS    = COORD_BITS + 2;
    localparam int E_BITS     = COORD_BITS + 3;
    localparam int GAP_BITS   = COORD_BITS + 2;
    localparam int SQP_BITS   = 2 * GAP_BITS;
    localparam int SQ_BITS    = SQP_BITS + 1;
    localparam int ROOT_BITS  = GAP_BITS + 1;

    // front stages: capture, differences, selects, clamps, squares, sums
    localparam int FRONT_STAGES = 6;
    localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_BITS;

    typedef logic [SQ_BITS-1:0]   rad_t;
    typedef logic [ROOT_BITS-1:0] root_t;

endpackage

### sv/rdm_isqrt.sv
module rdm_isqrt import rdm_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  rad_t  rad_in,
    output root_t root_out
);

    localparam int TRIAL_BITS = 2 * ROOT_BITS;

    // one root bit per stage, most significant bit first
    rad_t  rem_reg  [ROOT_BITS-1];
    root_t root_reg [ROOT_BITS];
    rad_t  rem_in   [ROOT_BITS];
    root_t root_in  [ROOT_BITS];

    assign rem_in[0]  = rad_in;
    assign root_in[0] = '0;

    genvar j;
    for (j = 0; j < ROOT_BITS; j++) begin : g_step
        localparam int B = ROOT_BITS - 1 - j;

        logic [TRIAL_BITS-1:0] trial;
        logic [TRIAL_BITS-1:0] rem_ext;
        logic                  fits;

        if (j > 0) begin : g_link
            assign rem_in[j]  = rem_reg[j-1];
            assign root_in[j] = root_reg[j-1];
        end

        // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
        assign trial   = (TRIAL_BITS'(root_in[j]) << (B + 1)) | (TRIAL_BITS'(1) << (2 * B));
        assign rem_ext = TRIAL_BITS'(rem_in[j]);
        assign fits    = rem_ext >= trial;

        // root bit decision
        always_ff @(posedge aclk) begin
            if (en) begin
                if (fits) begin
                    root_reg[j] <= root_in[j] | (ROOT_BITS'(1) << B);
                end else begin
                    root_reg[j] <= root_in[j];
                end
            end
        end

        // remainder, not needed after the last bit
        if (j < ROOT_BITS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (fits) begin
                        rem_reg[j] <= rem_in[j] - trial[SQ_BITS-1:0];
                    end else begin
                        rem_reg[j] <= rem_in[j];
                    end
                end
            end
        end
    end

    assign root_out = root_reg[ROOT_BITS-1];

endmodule

### sv/rectangle_distance_metrics_unit.sv
// a request passes the six front stages and the square-root stages, then the output register
// throughput: one request per cycle while the skid register is empty; a stalled output
// parks one result in the skid register; the two square-root pipelines find one root bit per
// stage (35 stages), behind six front stages for gaps, clamps, squares and sums
// reset: synchronous, active low; clears the stage valid bits, output and skid valid
module rectangle_distance_metrics_unit import rdm_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_ref_low_x,
    input  logic signed [COORD_BITS-1:0] s_ref_low_y,
    input  logic signed [COORD_BITS-1:0] s_ref_high_x,
    input  logic signed [COORD_BITS-1:0] s_ref_high_y,
    input  logic signed [COORD_BITS-1:0] s_query_low_x,
    input  logic signed [COORD_BITS-1:0] s_query_low_y,
    input  logic signed [COORD_BITS-1:0] s_query_high_x,
    input  logic signed [COORD_BITS-1:0] s_query_high_y,
    input  logic                         s_query_is_point,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_overlaps,
    output logic                         m_ref_contains_query,
    output logic [DIST_BITS-1:0]         m_min_distance,
    output logic [DIST_BITS-1:0]         m_far_distance
);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] lx;
        logic signed [COORD_BITS-1:0] ly;
        logic signed [COORD_BITS-1:0] hx;
        logic signed [COORD_BITS-1:0] hy;
        logic signed [COORD_BITS-1:0] qlx;
        logic signed [COORD_BITS-1:0] qly;
        logic signed [COORD_BITS-1:0] qhx;
        logic signed [COORD_BITS-1:0] qhy;
        logic                         is_point;
    } req_t;

    typedef struct packed {
        logic is_point;
        logic ovl;
        logic cont;
    } flags_t;

    // per axis after the difference stage
    typedef struct packed {
        logic signed [T2_BITS-1:0]    t2;
        logic signed [DIFF_BITS-1:0]  w;
        logic signed [DIFF_BITS-1:0]  da;
        logic signed [DIFF_BITS-1:0]  db;
        logic signed [DIFF_BITS-1:0]  pa;
        logic signed [COORD_BITS-1:0] hmax;
        logic signed [COORD_BITS-1:0] lmin;
    } ax1_t;

    // per axis after the select stage
    typedef struct packed {
        logic signed [E_BITS-1:0]    e_pos;
        logic signed [E_BITS-1:0]    e_neg;
        logic                        t2_neg;
        logic [GAP_BITS-1:0]         gbox;
        logic [DIFF_BITS-1:0]        ma;
        logic [DIFF_BITS-1:0]        mb;
        logic signed [DIFF_BITS-1:0] u_pos;
        logic signed [DIFF_BITS-1:0] u_neg;
    } ax2_t;

    // per axis square operands
    typedef struct packed {
        logic [GAP_BITS-1:0] min_op;
        logic [GAP_BITS-1:0] max_op;
    } ax3_t;

    typedef struct packed {
        logic [SQP_BITS-1:0] min_sq;
        logic [SQP_BITS-1:0] max_sq;
    } ax4_t;

    typedef struct packed {
        logic                 ovl;
        logic                 cont;
        logic [DIST_BITS-1:0] dmin;
        logic [DIST_BITS-1:0] dmax;
    } res_t;

    // differences of one axis
    function automatic ax1_t stage1_axis(
        logic signed [COORD_BITS-1:0] q,
        logic signed [COORD_BITS-1:0] qh,
        logic signed [COORD_BITS-1:0] l,
        logic signed [COORD_BITS-1:0] h
    );
        ax1_t a;
        a.t2   = (T2_BITS'(q) <<< 1) - T2_BITS'(l) - T2_BITS'(h);
        a.w    = DIFF_BITS'(h) - DIFF_BITS'(l);
        a.da   = DIFF_BITS'(q) - DIFF_BITS'(h);
        a.db   = DIFF_BITS'(l) - DIFF_BITS'(qh);
        a.pa   = DIFF_BITS'(q) - DIFF_BITS'(l);
        a.hmax = (h > qh) ? h : qh;
        a.lmin = (l < q) ? l : q;
        return a;
    endfunction

    // box gap, magnitudes and both signs of the point offset
    function automatic ax2_t stage2_axis(ax1_t a);
        ax2_t                        b;
        logic signed [E_BITS-1:0]    t2e;
        logic signed [E_BITS-1:0]    we;
        logic signed [DIFF_BITS-1:0] hm;
        logic signed [DIFF_BITS-1:0] lm;
        t2e      = E_BITS'($signed(a.t2));
        we       = E_BITS'($signed(a.w));
        hm       = DIFF_BITS'($signed(a.hmax));
        lm       = DIFF_BITS'($signed(a.lmin));
        b.e_pos  = t2e - we;
        b.e_neg  = -t2e - we;
        b.t2_neg = a.t2[T2_BITS-1];
        if ($signed(a.da) > 0) begin
            b.gbox = GAP_BITS'($unsigned(a.da));
        end else if ($signed(a.db) > 0) begin
            b.gbox = GAP_BITS'($unsigned(a.db));
        end else begin
            b.gbox = '0;
        end
        b.ma    = a.pa[DIFF_BITS-1] ? $unsigned(-$signed(a.pa)) : $unsigned(a.pa);
        b.mb    = a.da[DIFF_BITS-1] ? $unsigned(-$signed(a.da)) : $unsigned(a.da);
        b.u_pos = hm - lm;
        b.u_neg = lm - hm;
        return b;
    endfunction

    // clamp and pick the operands to square
    function automatic ax3_t stage3_axis(ax2_t b, flags_t f);
        ax3_t                     c;
        logic signed [E_BITS-1:0] chosen;
        logic [GAP_BITS-1:0]      pmin;
        logic [GAP_BITS-1:0]      pmax;
        logic [GAP_BITS-1:0]      bmax;
        chosen = b.t2_neg ? b.e_neg : b.e_pos;
        pmin   = chosen[E_BITS-1] ? '0 : chosen[GAP_BITS-1:0];
        pmax   = (b.ma > b.mb) ? GAP_BITS'(b.ma) : GAP_BITS'(b.mb);
        bmax   = b.u_pos[DIFF_BITS-1] ? GAP_BITS'($unsigned(b.u_neg))
                                      : GAP_BITS'($unsigned(b.u_pos));
        if (f.ovl) begin
            c.min_op = '0;
        end else begin
            c.min_op = f.is_point ? pmin : b.gbox;
        end
        c.max_op = f.is_point ? pmax : bmax;
        return c;
    endfunction

    logic [PIPE_STAGES-1:0] v_reg;
    logic                   pipe_en;
    logic                   emit;

    req_t   req_reg;
    ax1_t   ax1_x_reg, ax1_y_reg, ax1_x_next, ax1_y_next;
    ax2_t   ax2_x_reg, ax2_y_reg;
    ax3_t   ax3_x_reg, ax3_y_reg;
    ax4_t   ax4_x_reg, ax4_y_reg, ax4_x_next, ax4_y_next;
    rad_t   min_rad_reg, max_rad_reg;
    flags_t flags_reg [1:PIPE_STAGES-1];
    flags_t flags_next;

    root_t  min_root, max_root, min_scaled;
    res_t   pipe_result;

    logic   out_valid_reg, skid_valid_reg;
    res_t   out_data_reg, skid_data_reg;

    // whole pipeline moves while the skid register is empty
    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;
    assign emit    = pipe_en && v_reg[PIPE_STAGES-1];

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= {v_reg[PIPE_STAGES-2:0], s_valid};
        end
    end

    // overlap and containment tests, axis differences
    always_comb begin
        ax1_x_next = stage1_axis(req_reg.qlx, req_reg.qhx, req_reg.lx, req_reg.hx);
        ax1_y_next = stage1_axis(req_reg.qly, req_reg.qhy, req_reg.ly, req_reg.hy);
        flags_next.is_point = req_reg.is_point;
        if (req_reg.is_point) begin
            flags_next.cont = req_reg.qlx >= req_reg.lx && req_reg.qlx <= req_reg.hx &&
                              req_reg.qly >= req_reg.ly && req_reg.qly <= req_reg.hy;
            flags_next.ovl  = flags_next.cont;
        end else begin
            flags_next.ovl  = !(req_reg.qlx > req_reg.hx || req_reg.qhx < req_reg.lx ||
                                req_reg.qly > req_reg.hy || req_reg.qhy < req_reg.ly);
            flags_next.cont = req_reg.qlx >= req_reg.lx && req_reg.qhx <= req_reg.hx &&
                              req_reg.qly >= req_reg.ly && req_reg.qhy <= req_reg.hy;
        end
    end

    // squares
    always_comb begin
        ax4_x_next.min_sq = SQP_BITS'(ax3_x_reg.min_op) * SQP_BITS'(ax3_x_reg.min_op);
        ax4_x_next.max_sq = SQP_BITS'(ax3_x_reg.max_op) * SQP_BITS'(ax3_x_reg.max_op);
        ax4_y_next.min_sq = SQP_BITS'(ax3_y_reg.min_op) * SQP_BITS'(ax3_y_reg.min_op);
        ax4_y_next.max_sq = SQP_BITS'(ax3_y_reg.max_op) * SQP_BITS'(ax3_y_reg.max_op);
    end

    // front stage data
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            req_reg     <= '{s_ref_low_x, s_ref_low_y, s_ref_high_x, s_ref_high_y,
                             s_query_low_x, s_query_low_y, s_query_high_x, s_query_high_y,
                             s_query_is_point};
            ax1_x_reg   <= ax1_x_next;
            ax1_y_reg   <= ax1_y_next;
            ax2_x_reg   <= stage2_axis(ax1_x_reg);
            ax2_y_reg   <= stage2_axis(ax1_y_reg);
            ax3_x_reg   <= stage3_axis(ax2_x_reg, flags_reg[2]);
            ax3_y_reg   <= stage3_axis(ax2_y_reg, flags_reg[2]);
            ax4_x_reg   <= ax4_x_next;
            ax4_y_reg   <= ax4_y_next;
            min_rad_reg <= SQ_BITS'(ax4_x_reg.min_sq) + SQ_BITS'(ax4_y_reg.min_sq);
            max_rad_reg <= SQ_BITS'(ax4_x_reg.max_sq) + SQ_BITS'(ax4_y_reg.max_sq);
        end
    end

    // flags ride along with the data
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            flags_reg[1] <= flags_next;
            for (int k = 2; k < PIPE_STAGES; k++) begin
                flags_reg[k] <= flags_reg[k-1];
            end
        end
    end

    // square roots of both sums
    rdm_isqrt u_min_sqrt (
        .aclk     (aclk),
        .en       (pipe_en),
        .rad_in   (min_rad_reg),
        .root_out (min_root)
    );

    rdm_isqrt u_max_sqrt (
        .aclk     (aclk),
        .en       (pipe_en),
        .rad_in   (max_rad_reg),
        .root_out (max_root)
    );

    // point offsets were taken at doubled scale, then saturate
    always_comb begin
        min_scaled = flags_reg[PIPE_STAGES-1].is_point ? (min_root >> 1) : min_root;
        pipe_result.ovl  = flags_reg[PIPE_STAGES-1].ovl;
        pipe_result.cont = flags_reg[PIPE_STAGES-1].cont;
        pipe_result.dmin = (|min_scaled[ROOT_BITS-1:DIST_BITS]) ? '1
                                                               : min_scaled[DIST_BITS-1:0];
        pipe_result.dmax = (|max_root[ROOT_BITS-1:DIST_BITS]) ? '1
                                                             : max_root[DIST_BITS-1:0];
    end

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (emit) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (emit) begin
            if (!out_valid_reg || m_ready) begin
                out_data_reg <= pipe_result;
            end else begin
                skid_data_reg <= pipe_result;
            end
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_overlaps           = out_data_reg.ovl;
    assign m_ref_contains_query = out_data_reg.cont;
    assign m_min_distance       = out_data_reg.dmin;
    assign m_far_distance       = out_data_reg.dmax;

    // skid holds a result only behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output empty");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    // a result leaving the pipeline is never dropped
    a_emit_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> out_valid_reg)
        else $error("result lost at pipeline exit");

    // overlapping shapes have zero minimum distance
    a_ovl_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overlaps) |-> (m_min_distance == '0))
        else $error("nonzero minimum distance on overlap");

endmodule
